[rtl/core/acmka_pkg.sv]
// Shared types, command codes and GF(2^8) helpers for the AES column mix and key add unit.
`default_nettype none

package acmka_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_MIX     = 3'd1;
  localparam logic [2:0] CMD_INV_MIX = 3'd2;
  localparam logic [2:0] CMD_KEY_ADD = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // Internal operation classes: one-hot, except read, which is all zeros.
  typedef logic [3:0] op_t;
  localparam op_t OP_READ    = 4'b0000;
  localparam op_t OP_LOAD    = 4'b0001;
  localparam op_t OP_MIX     = 4'b0010;
  localparam op_t OP_INV_MIX = 4'b0100;
  localparam op_t OP_KEY_ADD = 4'b1000;

  // GF(2^8) reduction polynomial and the bit that triggers it.
  localparam logic [7:0] GF_REDUCE = 8'h1B;
  localparam logic [7:0] GF_TOPBIT = 8'h80;

  // One request as it travels from the front end to the back end.
  typedef struct packed {
    op_t          op;
    logic [127:0] operand;
  } req_t;

  // Multiply by two in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] s;
    s = {v[6:0], 1'b0};
    if ((v & GF_TOPBIT) != 8'h00) begin
      s = s ^ GF_REDUCE;
    end
    return s;
  endfunction

  // Forward MixColumns on one column; byte 0 sits in bits 31:24.
  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

  // Inverse MixColumns on one column (matrix row 14, 11, 13, 9).
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    a[0] = col[31:24];
    a[1] = col[23:16];
    a[2] = col[15:8];
    a[3] = col[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k]  = xtime(a[k]);
      x4[k]  = xtime(x2[k]);
      x8[k]  = xtime(x4[k]);
      m9[k]  = x8[k] ^ a[k];
      m11[k] = x8[k] ^ x2[k] ^ a[k];
      m13[k] = x8[k] ^ x4[k] ^ a[k];
      m14[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
  endfunction

endpackage

`default_nettype wire

[rtl/core/acmka_front.sv]
// Front end: takes requests from the input channel and classifies the command.
`default_nettype none

module acmka_front (
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            cmd,
  input  wire logic [63:0]           operand_hi,
  input  wire logic [63:0]           operand_lo,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output acmka_pkg::req_t            push_req
);

  acmka_pkg::op_t op;

  // Map the command code to an operation class; unused codes only read back.
  always_comb begin
    unique case (cmd)
      acmka_pkg::CMD_LOAD:    op = acmka_pkg::OP_LOAD;
      acmka_pkg::CMD_MIX:     op = acmka_pkg::OP_MIX;
      acmka_pkg::CMD_INV_MIX: op = acmka_pkg::OP_INV_MIX;
      acmka_pkg::CMD_KEY_ADD: op = acmka_pkg::OP_KEY_ADD;
      acmka_pkg::CMD_READ:    op = acmka_pkg::OP_READ;
      default:                op = acmka_pkg::OP_READ;
    endcase
  end

  // The request goes straight into the queue when it has room.
  assign push_req.op      = op;
  assign push_req.operand = {operand_hi, operand_lo};
  assign push_valid       = in_valid;
  assign in_ready         = push_ready;

endmodule

`default_nettype wire

[rtl/core/acmka_queue.sv]
// Short request queue between the front end and the back end.
`default_nettype none

module acmka_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire acmka_pkg::req_t  push_req,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output acmka_pkg::req_t       pop_req
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);

  acmka_pkg::req_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            push;
  logic            pop;

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_req    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy follows pushes and pops; both in one cycle leave it unchanged.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  // Request storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

[rtl/core/acmka_back.sv]
// Back end: holds the AES state, executes queued requests and presents the result.
`default_nettype none

module acmka_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire acmka_pkg::req_t  pop_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [63:0]           state_hi,
  output logic [63:0]           state_lo
);

  logic [127:0] state;
  logic [127:0] state_next;
  logic [127:0] mixed;
  logic [127:0] inv_mixed;
  logic         fire;

  // Each column is four consecutive bytes, byte 0 in the top bits.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mixed[127-32*c -: 32]     = acmka_pkg::mix_col(state[127-32*c -: 32]);
      inv_mixed[127-32*c -: 32] = acmka_pkg::inv_mix_col(state[127-32*c -: 32]);
    end
  end

  // Select the new state by operation class.
  always_comb begin
    unique case (pop_req.op)
      acmka_pkg::OP_LOAD:    state_next = pop_req.operand;
      acmka_pkg::OP_MIX:     state_next = mixed;
      acmka_pkg::OP_INV_MIX: state_next = inv_mixed;
      acmka_pkg::OP_KEY_ADD: state_next = state ^ pop_req.operand;
      acmka_pkg::OP_READ:    state_next = state;
      default:               state_next = state;
    endcase
  end

  // A request runs when the output register is free or being emptied.
  assign pop_ready = !out_valid || out_ready;
  assign fire      = pop_valid && pop_ready;

  // The state register doubles as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign state_hi = state[127:64];
  assign state_lo = state[63:0];

  // The state only changes when a request is executed.
  assert property (@(posedge clk) disable iff (rst) !fire |=> $stable(state))
    else $error("state changed without an executed request");

  // Every executed request leaves a result on the output.
  assert property (@(posedge clk) disable iff (rst) fire |=> out_valid)
    else $error("executed request produced no result");

  // Reset leaves a zero state and no pending result.
  assert property (@(posedge clk) rst |=> (state == '0) && !out_valid)
    else $error("reset did not clear the state");

endmodule

`default_nettype wire

[rtl/core/aes_column_mix_key_add_unit.sv]
// Top level of the AES column mix and key add unit.
// Holds a 16-byte AES state (byte 0 in the top bits of state_hi) and, while results
// are taken, executes one request per cycle: load, MixColumns, InvMixColumns, round
// key XOR or read back; codes 5 to 7 behave as read. Every request returns the state
// after it. Sustained rate is one request per clock while out_ready is high; a request
// is written into the queue, then executed from the queue into the state register,
// which holds its result. The front end accepts while the queue has room (QUEUE_DEPTH
// entries), so the input keeps flowing while a result waits, until the queue is full.
`default_nettype none

module aes_column_mix_key_add_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] operand_hi,
  input  wire logic [63:0] operand_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      state_hi,
  output logic [63:0]      state_lo
);

  logic            push_valid;
  logic            push_ready;
  acmka_pkg::req_t push_req;
  logic            pop_valid;
  logic            pop_ready;
  acmka_pkg::req_t pop_req;

  acmka_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .operand_hi (operand_hi),
    .operand_lo (operand_lo),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  acmka_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  acmka_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_req   (pop_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .state_hi  (state_hi),
    .state_lo  (state_lo)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the AES column mix and key add unit, with its own state predictor.
module tb;

  localparam int RANDOM_ITEMS    = 1600;
  localparam int IDLE_LIMIT      = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 400;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        drain_first;
  } aes_request_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } state_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [63:0] operand_hi;
  logic [63:0] operand_lo;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] state_hi;
  logic [63:0] state_lo;

  aes_request_t pending_requests[$];
  state_word_t  expected_states[$];
  logic [7:0]   aes_bytes [16];

  int  fail_count;
  int  accepted_items;
  int  idle_cycles;
  bit  in_taken;
  int  burst_left;
  int  gap_left;
  int  stall_mode;
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  aes_column_mix_key_add_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .operand_hi (operand_hi),
    .operand_lo (operand_lo),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .state_hi   (state_hi),
    .state_lo   (state_lo)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Doubling in GF(2^8) with the AES reduction.
  function automatic logic [7:0] gf_twice(input logic [7:0] b);
    logic [7:0] s;
    s = {b[6:0], 1'b0};
    if (b[7]) begin
      s = s ^ acmka_pkg::GF_REDUCE;
    end
    return s;
  endfunction

  // Multiplication by a four-bit constant, one doubling per coefficient bit.
  function automatic logic [7:0] gf_times(input logic [7:0] b, input logic [3:0] k);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p = b;
    for (int i = 0; i < 4; i++) begin
      if (k[i]) begin
        acc = acc ^ p;
      end
      p = gf_twice(p);
    end
    return acc;
  endfunction

  // Multiplies every column of the held state by a circulant matrix.
  task automatic mix_columns(input logic [3:0] c0, input logic [3:0] c1,
                             input logic [3:0] c2, input logic [3:0] c3);
    logic [3:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    coef = '{c0, c1, c2, c3};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        col[r] = aes_bytes[c * 4 + r];
      end
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_times(col[k], coef[(k - r) & 3]);
        end
        aes_bytes[c * 4 + r] = acc;
      end
    end
  endtask

  // Applies one request to the predicted state and returns the state after it.
  task automatic predict_state(input aes_request_t req, output state_word_t res);
    logic [7:0] op_bytes [16];
    for (int i = 0; i < 8; i++) begin
      op_bytes[i]     = req.hi[63 - 8 * i -: 8];
      op_bytes[8 + i] = req.lo[63 - 8 * i -: 8];
    end
    case (req.cmd)
      acmka_pkg::CMD_LOAD: begin
        for (int i = 0; i < 16; i++) aes_bytes[i] = op_bytes[i];
      end
      acmka_pkg::CMD_MIX: begin
        mix_columns(4'd2, 4'd3, 4'd1, 4'd1);
      end
      acmka_pkg::CMD_INV_MIX: begin
        mix_columns(4'd14, 4'd11, 4'd13, 4'd9);
      end
      acmka_pkg::CMD_KEY_ADD: begin
        for (int i = 0; i < 16; i++) aes_bytes[i] = aes_bytes[i] ^ op_bytes[i];
      end
      default: begin
        // Read and the unused codes leave the state alone.
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8 * i -: 8] = aes_bytes[i];
      res.lo[63 - 8 * i -: 8] = aes_bytes[8 + i];
    end
  endtask

  task automatic queue_request(input logic [2:0] c, input logic [63:0] hi,
                               input logic [63:0] lo, input bit drain);
    aes_request_t req;
    req.cmd = c;
    req.hi = hi;
    req.lo = lo;
    req.drain_first = drain;
    pending_requests.push_back(req);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    case ($urandom_range(0, 15))
      0: v = 64'h0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Accepted requests feed the predictor; accepted results are checked against it.
  always @(posedge clk) begin
    state_word_t predicted;
    state_word_t oldest;
    bit fired;
    fired = 1'b0;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_state('{cmd: cmd, hi: operand_hi, lo: operand_lo, drain_first: 1'b0},
                      predicted);
        expected_states.push_back(predicted);
        accepted_items++;
        in_taken = 1'b1;
        fired = 1'b1;
      end
      if (out_valid && out_ready) begin
        fired = 1'b1;
        if (expected_states.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result: state_hi=%h state_lo=%h", state_hi, state_lo);
          end
        end else begin
          oldest = expected_states.pop_front();
          if (state_hi !== oldest.hi || state_lo !== oldest.lo) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("state mismatch: expected %h_%h, got %h_%h",
                       oldest.hi, oldest.lo, state_hi, state_lo);
            end
          end
        end
      end
      // Watchdog on cycles where neither channel moves.
      if (fired) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("aes_column_mix_key_add_unit verification failed");
          $finish;
        end
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    aes_request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain_first && expected_states.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        cmd <= nxt.cmd;
        operand_hi <= nxt.hi;
        operand_lo <= nxt.lo;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) :
                                                   $urandom_range(0, 4);
        end
      end
    end
  end

  // Result receiver: stall patterns in segments, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_items >= HOLD_OFF_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= stall_left[1];
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int made;
    int steps;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = acmka_pkg::CMD_READ;
    operand_hi = 64'h0;
    operand_lo = 64'h0;
    out_ready = 1'b0;
    fail_count = 0;
    accepted_items = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    for (int i = 0; i < 16; i++) aes_bytes[i] = 8'h00;

    // Directed part: reset state, extremes, the known MixColumns columns and unused codes.
    queue_request(acmka_pkg::CMD_READ, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_LOAD, '1, '1, 1'b0);
    queue_request(acmka_pkg::CMD_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_INV_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_KEY_ADD, '1, '1, 1'b0);
    queue_request(acmka_pkg::CMD_LOAD, 64'hdb135345_f20a225c, 64'h01010101_c6c6c6c6, 1'b0);
    queue_request(acmka_pkg::CMD_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_INV_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_MIX, '1, '1, 1'b0);
    queue_request(acmka_pkg::CMD_INV_MIX, 64'h12345678_9abcdef0, 64'h0fedcba9_87654321,
                  1'b0);
    queue_request(acmka_pkg::CMD_READ, '1, '1, 1'b0);
    queue_request(3'd5, 64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555, 1'b0);
    queue_request(3'd6, '1, '1, 1'b0);
    queue_request(3'd7, 64'h55555555_55555555, 64'haaaaaaaa_aaaaaaaa, 1'b0);
    queue_request(acmka_pkg::CMD_KEY_ADD, 64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555,
                  1'b0);
    queue_request(acmka_pkg::CMD_LOAD, 64'h80808080_80808080, 64'h80808080_80808080, 1'b0);
    queue_request(acmka_pkg::CMD_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_LOAD, 64'h80808080_80808080, 64'h80808080_80808080, 1'b0);
    queue_request(acmka_pkg::CMD_INV_MIX, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_KEY_ADD, 64'h0, 64'h0, 1'b0);
    queue_request(acmka_pkg::CMD_LOAD, 64'h0, 64'h0, 1'b0);

    // Random part: a load followed by a run of transforms, with some noise mixed in.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      queue_request(acmka_pkg::CMD_LOAD, random_operand(), random_operand(),
                    (made >= 800 && made < 805) || (made >= 1300 && made < 1305));
      made++;
      steps = $urandom_range(2, 12);
      for (int s = 0; s < steps; s++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: queue_request(acmka_pkg::CMD_MIX, random_operand(),
                                          random_operand(), 1'b0);
          6, 7, 8, 9, 10, 11: queue_request(acmka_pkg::CMD_INV_MIX, random_operand(),
                                            random_operand(), 1'b0);
          12, 13, 14, 15: queue_request(acmka_pkg::CMD_KEY_ADD, random_operand(),
                                        random_operand(), 1'b0);
          16, 17: queue_request(acmka_pkg::CMD_READ, random_operand(), random_operand(),
                                1'b0);
          default: queue_request(3'($urandom_range(5, 7)), random_operand(),
                                 random_operand(), 1'b0);
        endcase
        made++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_states.size() == 0) begin
      $display("aes_column_mix_key_add_unit verification clean");
    end else begin
      $display("aes_column_mix_key_add_unit verification failed");
    end
    $finish;
  end

endmodule
